// File: src/wmcc_pkg.sv
// Shared types and constants for the windowed message class counter.
package wmcc_pkg;

    localparam int TB_W    = 8;
    localparam int SUM_W   = 24;
    localparam int NUM_CLS = 4;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // operation field codes
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // class index = {forwarded, bulletin}
    localparam logic [1:0] CLS_LP = 2'd0;
    localparam logic [1:0] CLS_LB = 2'd1;
    localparam logic [1:0] CLS_FP = 2'd2;
    localparam logic [1:0] CLS_FB = 2'd3;

    typedef struct packed {
        logic load;
        logic reduce;
        logic advance;
        logic rd_cur;
        logic wr;
        logic sum_rd;
        logic out_load;
    } wmcc_cmd_t;

    typedef struct packed {
        logic red_ge;
        logic record;
        logic cnt_last;
    } wmcc_sts_t;

endpackage

// File: src/windowed_message_class_counter_core.sv
// Each transaction loads the item, subtracts NUM_BINS until time_bin is below NUM_BINS,
// advances the ring, reads and writes the current bin if recording, then sums N bins,
// one memory read per bin (N is WINDOW_BINS, or NUM_BINS for a whole-day report).
// One transaction in flight; the next is taken while the last result waits.
// aresetn (synchronous, active low) empties all bins at once through per-bin valid flags
// and sets the last-bin pointer to zero; no clearing pass is needed.
module windowed_message_class_counter_core #(
    parameter int NUM_BINS        = 240,
    parameter int WINDOW_BINS     = 7,
    parameter int BIN_COUNT_WIDTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_operation,
    input  logic [wmcc_pkg::TB_W-1:0]  s_time_bin,
    input  logic                       s_is_local,
    input  logic                       s_is_private,
    input  logic                       s_whole_day,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [wmcc_pkg::SUM_W-1:0] m_sum_local_private,
    output logic [wmcc_pkg::SUM_W-1:0] m_sum_local_bulletin,
    output logic [wmcc_pkg::SUM_W-1:0] m_sum_forward_private,
    output logic [wmcc_pkg::SUM_W-1:0] m_sum_forward_bulletin
);

    wmcc_pkg::wmcc_cmd_t cmd;
    wmcc_pkg::wmcc_sts_t sts;

    wmcc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    wmcc_dp #(
        .NUM_BINS        (NUM_BINS),
        .WINDOW_BINS     (WINDOW_BINS),
        .BIN_COUNT_WIDTH (BIN_COUNT_WIDTH)
    ) u_dp (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cmd                    (cmd),
        .sts                    (sts),
        .s_operation            (s_operation),
        .s_time_bin             (s_time_bin),
        .s_is_local             (s_is_local),
        .s_is_private           (s_is_private),
        .s_whole_day            (s_whole_day),
        .m_sum_local_private    (m_sum_local_private),
        .m_sum_local_bulletin   (m_sum_local_bulletin),
        .m_sum_forward_private  (m_sum_forward_private),
        .m_sum_forward_bulletin (m_sum_forward_bulletin)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a transaction is in progress");

    a_no_wr_during_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.wr && cmd.sum_rd))
        else $error("bin write collides with window read");

    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result overwrites an unaccepted result");

    a_sum_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sum_rd && sts.cnt_last |=> !cmd.sum_rd)
        else $error("window read runs past its bin count");
`endif

endmodule

// File: src/wmcc_dp.sv
// Datapath: bin memory, valid bits, ring pointers and class accumulators.
module wmcc_dp #(
    parameter int NUM_BINS        = 240,
    parameter int WINDOW_BINS     = 7,
    parameter int BIN_COUNT_WIDTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  wmcc_pkg::wmcc_cmd_t          cmd,
    output wmcc_pkg::wmcc_sts_t          sts,
    input  logic                         s_operation,
    input  logic [wmcc_pkg::TB_W-1:0]    s_time_bin,
    input  logic                         s_is_local,
    input  logic                         s_is_private,
    input  logic                         s_whole_day,
    output logic [wmcc_pkg::SUM_W-1:0]   m_sum_local_private,
    output logic [wmcc_pkg::SUM_W-1:0]   m_sum_local_bulletin,
    output logic [wmcc_pkg::SUM_W-1:0]   m_sum_forward_private,
    output logic [wmcc_pkg::SUM_W-1:0]   m_sum_forward_bulletin
);

    localparam int TB_W  = wmcc_pkg::TB_W;
    localparam int SUM_W = wmcc_pkg::SUM_W;
    localparam int NCLS  = wmcc_pkg::NUM_CLS;
    localparam int BCW   = BIN_COUNT_WIDTH;
    localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int CNT_W = $clog2(NUM_BINS + 1);
    localparam int WIN_N = (WINDOW_BINS < NUM_BINS) ? WINDOW_BINS : NUM_BINS;
    localparam int ENT_W = NCLS * BCW;
    localparam int ADD_W = ((BCW > SUM_W) ? BCW : SUM_W) + 1;

    logic             op_reg;
    logic [TB_W-1:0]  red_reg;
    logic             loc_reg;
    logic             prv_reg;
    logic             whole_reg;
    logic [1:0]       cls;
    logic [BIN_W-1:0] cur_bin;
    logic [BIN_W-1:0] last_bin_reg;
    logic [BIN_W-1:0] pos_reg;
    logic [BIN_W-1:0] pos_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic [NUM_BINS-1:0] vld_reg;
    logic [NUM_BINS-1:0] vld_next;
    logic [NUM_BINS-1:0] clr_vec;

    logic [ENT_W-1:0] mem [NUM_BINS];
    logic [ENT_W-1:0] rdata_reg;
    logic             rvld_reg;
    logic [BIN_W-1:0] raddr;
    logic             rd_en;
    logic [ENT_W-1:0] ent;
    logic [ENT_W-1:0] wdata;

    logic             acc_en_reg;
    logic [SUM_W-1:0] acc_reg  [NCLS];
    logic [SUM_W-1:0] acc_next [NCLS];
    logic [ADD_W-1:0] add_sum  [NCLS];
    logic [SUM_W-1:0] out_reg  [NCLS];

    assign cls     = {~loc_reg, ~prv_reg};
    assign cur_bin = BIN_W'(red_reg);

    assign sts.red_ge   = 32'(red_reg) >= 32'(NUM_BINS);
    assign sts.record   = op_reg == wmcc_pkg::OP_RECORD;
    assign sts.cnt_last = cnt_reg == CNT_W'(1);

    // item registers; the bin number is reduced in place
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_operation;
            red_reg   <= s_time_bin;
            loc_reg   <= s_is_local;
            prv_reg   <= s_is_private;
            whole_reg <= s_whole_day;
        end else if (cmd.reduce) begin
            red_reg <= red_reg - TB_W'(NUM_BINS);
        end
    end

    // bins strictly after last_bin up to and including cur_bin, around the ring
    always_comb begin
        clr_vec = '0;
        for (int i = 0; i < NUM_BINS; i++) begin
            if (last_bin_reg < cur_bin) begin
                clr_vec[i] = (BIN_W'(i) > last_bin_reg) && (BIN_W'(i) <= cur_bin);
            end else if (last_bin_reg > cur_bin) begin
                clr_vec[i] = (BIN_W'(i) > last_bin_reg) || (BIN_W'(i) <= cur_bin);
            end
        end
    end

    always_comb begin
        vld_next = vld_reg;
        if (cmd.advance) begin
            vld_next = vld_reg & ~clr_vec;
        end
        if (cmd.wr) begin
            vld_next[cur_bin] = 1'b1;
        end
    end

    always_comb begin
        pos_next = pos_reg;
        cnt_next = cnt_reg;
        if (cmd.advance) begin
            pos_next = cur_bin;
            cnt_next = whole_reg ? CNT_W'(NUM_BINS) : CNT_W'(WIN_N);
        end else if (cmd.sum_rd) begin
            pos_next = (pos_reg == '0) ? BIN_W'(NUM_BINS - 1) : pos_reg - 1'b1;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            last_bin_reg <= '0;
            pos_reg      <= '0;
            cnt_reg      <= '0;
            acc_en_reg   <= 1'b0;
        end else begin
            vld_reg    <= vld_next;
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            acc_en_reg <= cmd.sum_rd;
            if (cmd.advance) begin
                last_bin_reg <= cur_bin;
            end
        end
    end

    assign raddr = cmd.sum_rd ? pos_reg : cur_bin;
    assign rd_en = cmd.rd_cur | cmd.sum_rd;

    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            mem[cur_bin] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[raddr];
            rvld_reg  <= vld_reg[raddr];
        end
    end

    // a bin not written since it was cleared reads as zero
    assign ent = rvld_reg ? rdata_reg : '0;

    always_comb begin
        wdata = ent;
        for (int k = 0; k < NCLS; k++) begin
            if (2'(k) == cls && ent[k*BCW +: BCW] != {BCW{1'b1}}) begin
                wdata[k*BCW +: BCW] = ent[k*BCW +: BCW] + 1'b1;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NCLS; k++) begin
            add_sum[k]  = ADD_W'(acc_reg[k]) + ADD_W'(ent[k*BCW +: BCW]);
            acc_next[k] = acc_reg[k];
            if (cmd.load) begin
                acc_next[k] = '0;
            end else if (acc_en_reg) begin
                acc_next[k] = (add_sum[k] > ADD_W'(wmcc_pkg::SUM_MAX)) ?
                              wmcc_pkg::SUM_MAX : SUM_W'(add_sum[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NCLS; k++) begin
            acc_reg[k] <= acc_next[k];
            if (cmd.out_load) begin
                out_reg[k] <= acc_reg[k];
            end
        end
    end

    assign m_sum_local_private    = out_reg[wmcc_pkg::CLS_LP];
    assign m_sum_local_bulletin   = out_reg[wmcc_pkg::CLS_LB];
    assign m_sum_forward_private  = out_reg[wmcc_pkg::CLS_FP];
    assign m_sum_forward_bulletin = out_reg[wmcc_pkg::CLS_FB];

endmodule

// File: src/wmcc_ctrl.sv
// Controller: sequences reduce, advance, record and window sum per transaction.
module wmcc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  wmcc_pkg::wmcc_sts_t sts,
    output wmcc_pkg::wmcc_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_REDUCE  = 3'd1;
    localparam logic [2:0] ST_ADVANCE = 3'd2;
    localparam logic [2:0] ST_RD      = 3'd3;
    localparam logic [2:0] ST_WR      = 3'd4;
    localparam logic [2:0] ST_SUM     = 3'd5;
    localparam logic [2:0] ST_DRAIN   = 3'd6;
    localparam logic [2:0] ST_DONE    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (sts.red_ge) begin
                    cmd.reduce = 1'b1;
                end else begin
                    state_next = ST_ADVANCE;
                end
            end
            ST_ADVANCE: begin
                cmd.advance = 1'b1;
                state_next  = sts.record ? ST_RD : ST_SUM;
            end
            ST_RD: begin
                cmd.rd_cur = 1'b1;
                state_next = ST_WR;
            end
            ST_WR: begin
                cmd.wr     = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_rd = 1'b1;
                if (sts.cnt_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
